### rtl/core/cfpc_pkg.sv
// shared constants, codes and types of the control-flow path checker
package cfpc_pkg;

  // sizes
  localparam int TABLE_DEPTH = 256;
  localparam int STACK_DEPTH = 16;
  localparam int TAW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SAW         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int ID_W     = 32;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 5;

  // built-in start node
  localparam logic [ID_W-1:0] START_ID    = 32'h0000_0001;
  localparam logic [ID_W-1:0] FIRST_RESET = 32'h0002_0001;

  // node kinds
  localparam logic [KIND_W-1:0] KIND_RETURN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BRANCH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CALL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

  // item functions
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MOVED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd3;

  // one table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   next_a;
    logic [ID_W-1:0]   next_b;
  } entry_t;

  // table write from a load transaction
  typedef struct packed {
    logic           wr;
    logic [TAW-1:0] addr;
    entry_t         entry;
  } load_t;

  // lookup request
  typedef struct packed {
    logic            start;
    logic [ID_W-1:0] target;
  } scan_req_t;

  // lookup answer, meaningful while done is high
  typedef struct packed {
    logic   done;
    logic   hit;
    entry_t entry;
  } scan_res_t;

endpackage

### rtl/core/cfpc_ifs.sv
// channel interfaces of the control-flow path checker

// input item channel
interface cfpc_item_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] block_id;
  logic [7:0]  slot;
  logic [2:0]  kind;
  logic [31:0] next_a;
  logic [31:0] next_b;

  modport source (output valid, func, block_id, slot, kind, next_a, next_b, input ready);
  modport sink (input valid, func, block_id, slot, kind, next_a, next_b, output ready);
endinterface

// result channel
interface cfpc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] current_block;
  logic [4:0]  depth_now;

  modport source (output valid, status, current_block, depth_now, input ready);
  modport sink (input valid, status, current_block, depth_now, output ready);
endinterface

// configuration write channel
interface cfpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/control_flow_path_checker.sv
// control-flow path checker top level: sequencer, current node and return stack
//
// Load transactions write one node (id, kind, two successors) into a table of
// TABLE_DEPTH slots, and their result passes through the response state into
// the output register. A check transaction looks up the block id in the table
// one slot per cycle through the table memory's single read port, stopping at
// the lowest matching valid slot, and an unknown id scans all TABLE_DEPTH slots.
// A return node first reads the return stack memory, then does the lookup.
// Checks that fail on the current node alone go to the response without a
// lookup. One transaction is in work at a time. A new one is taken while the
// previous result still waits on the result channel. Register writes are taken
// only between transactions, and they go ahead of a waiting item. The table
// valid bits are cleared by reset at once, so no clearing pass is needed.
module control_flow_path_checker (
  input  logic          clk,
  input  logic          rst,
  cfpc_cfg_if.sink      cfg,
  cfpc_item_if.sink     item,
  cfpc_result_if.source result
);
  import cfpc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_RESP
  } state_t;

  state_t              state;
  logic [ID_W-1:0]     first_id;
  logic [ID_W-1:0]     cur_id;
  logic [KIND_W-1:0]   cur_kind;
  logic [ID_W-1:0]     cur_next_a;
  logic [ID_W-1:0]     cur_next_b;
  logic                at_start;
  logic [CNT_W-1:0]    count;
  logic [ID_W-1:0]     target;
  logic                is_call;
  logic                scan_go;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_block;
  logic [DEPTH_W-1:0]  out_depth;

  logic                accept;
  logic                chk_ok;
  logic                pop;
  logic                stk_re;
  logic                stk_we;
  logic [ID_W-1:0]     stk_rdata;
  load_t               ld;
  scan_req_t           scan_req;
  scan_res_t           scan_res;

  // handshakes
  assign accept               = item.valid && item.ready;
  assign item.ready           = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready            = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.current_block = out_block;
  assign result.depth_now     = out_depth;

  // table write straight from a load transaction
  always_comb begin
    ld.wr           = accept && (item.func == FUNC_LOAD)
                      && (32'(item.slot) < 32'(TABLE_DEPTH));
    ld.addr         = TAW'(item.slot);
    ld.entry.id     = item.block_id;
    ld.entry.kind   = item.kind;
    ld.entry.next_a = item.next_a;
    ld.entry.next_b = item.next_b;
  end

  assign scan_req.start  = scan_go;
  assign scan_req.target = target;

  cfpc_scan u_scan (
    .clk(clk),
    .rst(rst),
    .ld (ld),
    .req(scan_req),
    .res(scan_res)
  );

  // return stack: pop read on accept, push on a successful call
  assign stk_re = accept && (item.func == FUNC_CHECK) && pop;
  assign stk_we = (state == S_SCAN) && scan_res.done && is_call
                  && (scan_res.hit || (target == START_ID));

  cfpc_ram #(
    .WIDTH(ID_W),
    .DEPTH(STACK_DEPTH)
  ) u_stk_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(SAW'(count)),
    .wdata(cur_next_b),
    .re   (stk_re),
    .raddr(SAW'(count - 1'b1)),
    .rdata(stk_rdata)
  );

  // what the current node allows for the incoming id
  always_comb begin
    chk_ok = 1'b0;
    pop    = 1'b0;
    unique case (cur_kind)
      KIND_RETURN: pop    = (count != '0);
      KIND_SINGLE: chk_ok = (item.block_id == cur_next_a);
      KIND_BRANCH: chk_ok = (item.block_id == cur_next_a) || (item.block_id == cur_next_b);
      KIND_CALL:   chk_ok = (item.block_id == cur_next_a) && (count < CNT_W'(STACK_DEPTH));
      default:     chk_ok = 1'b0;
    endcase
  end

  // sequencer, current node, stack count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_id   <= FIRST_RESET;
      cur_id     <= START_ID;
      cur_kind   <= KIND_SINGLE;
      cur_next_a <= FIRST_RESET;
      cur_next_b <= '0;
      at_start   <= 1'b1;
      count      <= '0;
      scan_go    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      scan_go <= 1'b0;

      // configuration write, only while idle
      if (cfg.valid && cfg.ready) begin
        first_id <= cfg.data;
        if (at_start) begin
          cur_next_a <= cfg.data;
        end
      end

      // output register: load a finished result, or empty once taken
      if ((state == S_RESP) && (!out_valid || result.ready)) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_block  <= cur_id;
        out_depth  <= DEPTH_W'(count);
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.func == FUNC_LOAD) begin
              res_status <= ST_LOADED;
              state      <= S_RESP;
            end else if (pop) begin
              count   <= count - 1'b1;
              is_call <= 1'b0;
              state   <= S_POP;
            end else if (chk_ok) begin
              target  <= item.block_id;
              is_call <= (cur_kind == KIND_CALL);
              scan_go <= 1'b1;
              state   <= S_SCAN;
            end else begin
              cur_id     <= START_ID;
              cur_kind   <= KIND_SINGLE;
              cur_next_a <= first_id;
              cur_next_b <= '0;
              at_start   <= 1'b1;
              res_status <= ST_ERROR;
              state      <= S_RESP;
            end
          end
        end
        S_POP: begin
          target  <= stk_rdata;
          scan_go <= 1'b1;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_res.done) begin
            state <= S_RESP;
            if (scan_res.hit && (scan_res.entry.kind == KIND_END)) begin
              cur_id     <= START_ID;
              cur_kind   <= KIND_SINGLE;
              cur_next_a <= first_id;
              cur_next_b <= '0;
              at_start   <= 1'b1;
              count      <= '0;
              res_status <= ST_END;
            end else if (scan_res.hit) begin
              cur_id     <= target;
              cur_kind   <= scan_res.entry.kind;
              cur_next_a <= scan_res.entry.next_a;
              cur_next_b <= scan_res.entry.next_b;
              at_start   <= 1'b0;
              if (is_call) begin
                count <= count + 1'b1;
              end
              res_status <= ST_MOVED;
            end else if (target == START_ID) begin
              cur_id     <= START_ID;
              cur_kind   <= KIND_SINGLE;
              cur_next_a <= first_id;
              cur_next_b <= '0;
              at_start   <= 1'b1;
              if (is_call) begin
                count <= count + 1'b1;
              end
              res_status <= ST_MOVED;
            end else begin
              cur_id     <= START_ID;
              cur_kind   <= KIND_SINGLE;
              cur_next_a <= first_id;
              cur_next_b <= '0;
              at_start   <= 1'b1;
              res_status <= ST_ERROR;
            end
          end
        end
        S_RESP: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // return stack never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(STACK_DEPTH))
    else $error("return stack count beyond depth");

  // an accepted transaction keeps the input from being ready in the cycle after
  assert property (@(posedge clk) disable iff (rst) accept |=> !item.ready)
    else $error("input accepted on consecutive cycles");

  // a finished lookup always leads to a response
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && scan_res.done |=> (state == S_RESP))
    else $error("lookup finished without response");

  // start-node flag implies the start node is current
  assert property (@(posedge clk) disable iff (rst)
    at_start |-> (cur_id == START_ID) && (cur_kind == KIND_SINGLE))
    else $error("start flag set away from start node");

  // a push only happens on a call below full depth
  assert property (@(posedge clk) disable iff (rst)
    stk_we |-> is_call && (count < CNT_W'(STACK_DEPTH)))
    else $error("stack push without room");

endmodule

### rtl/core/cfpc_ram.sv
// generic simple dual-port ram with registered read
module cfpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cfpc_scan.sv
// node table storage, valid bits and the one-slot-per-cycle id lookup
module cfpc_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  cfpc_pkg::load_t      ld,
  input  cfpc_pkg::scan_req_t  req,
  output cfpc_pkg::scan_res_t  res
);
  import cfpc_pkg::*;

  logic [TABLE_DEPTH-1:0] valid;
  logic [TAW-1:0]         addr;
  logic                   active;
  logic                   more;
  logic                   chk;
  logic                   vld_d;
  logic                   last_d;
  logic                   issue;
  logic                   addr_last;
  entry_t                 rd_entry;

  assign issue     = active && more;
  assign addr_last = (addr == TAW'(TABLE_DEPTH - 1));

  // table memory
  cfpc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_tbl_ram (
    .clk  (clk),
    .we   (ld.wr),
    .waddr(ld.addr),
    .wdata(ld.entry),
    .re   (issue),
    .raddr(addr),
    .rdata(rd_entry)
  );

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ld.wr) begin
      valid[ld.addr] <= 1'b1;
    end
  end

  // compare the slot read last cycle; lowest matching slot ends the scan
  always_comb begin
    res.hit   = chk && vld_d && (rd_entry.id == req.target);
    res.done  = chk && (res.hit || last_d);
    res.entry = rd_entry;
  end

  // scan address sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      more   <= 1'b0;
      chk    <= 1'b0;
    end else if (req.start) begin
      active <= 1'b1;
      more   <= 1'b1;
      chk    <= 1'b0;
      addr   <= '0;
    end else if (res.done) begin
      active <= 1'b0;
      more   <= 1'b0;
      chk    <= 1'b0;
    end else if (active) begin
      chk    <= issue;
      vld_d  <= valid[addr];
      last_d <= addr_last;
      if (issue) begin
        if (addr_last) begin
          more <= 1'b0;
        end else begin
          addr <= addr + 1'b1;
        end
      end
    end
  end

endmodule
